// File: sv/efht_pkg.sv
`timescale 1ns / 1ps

package efht_pkg;

  // Table geometry. TABLE_SIZE must be a power of two: the slot index is
  // taken from the low bits of the hash and the probe wraps naturally.
  localparam int TABLE_SIZE    = 1024;
  localparam int MAX_FACES     = 4;
  localparam int RESULT_LIMIT  = 4;

  localparam int SLOT_W        = $clog2(TABLE_SIZE);
  localparam int FACE_DEPTH    = TABLE_SIZE * MAX_FACES;
  localparam int FADDR_W       = $clog2(FACE_DEPTH);
  localparam int CNT_W         = $clog2(MAX_FACES + 1);
  localparam int EDGE_W        = $clog2(TABLE_SIZE) + 1;
  localparam int RES_CNT_W     = $clog2(RESULT_LIMIT + 1);
  localparam int RES_IDX_W     = $clog2(RESULT_LIMIT);

  // A new edge is refused once (edge_count + 1) * 2 would reach TABLE_SIZE.
  localparam int FULL_LIMIT    = (TABLE_SIZE + 1) / 2 - 1;

  // Field widths.
  localparam int VERTEX_W      = 24;
  localparam int FACE_W        = 20;
  localparam int STATUS_W      = 3;
  localparam int HASH_W        = 32;

  // Hash multipliers.
  localparam int MULT_W        = 21;
  localparam logic [MULT_W-1:0] MULT_LOW  = MULT_W'(1400627);
  localparam logic [MULT_W-1:0] MULT_HIGH = MULT_W'(79823);

  // Request function codes.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEGENERATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LIST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;

  // One slot of the edge table.
  typedef struct packed {
    logic                used;
    logic [CNT_W-1:0]    count;
    logic [VERTEX_W-1:0] low;
    logic [VERTEX_W-1:0] high;
  } slot_t;

endpackage

// File: sv/efht_ram.sv
`timescale 1ns / 1ps

module efht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/edge_face_hash_table.sv
// Edge-to-face hash table with linear probing. Each request names an edge by
// two vertex indices (either order) and a face id. An add enters the edge if
// it is new and appends the face to its list, giving one result with a
// status; a query returns every stored face of the edge other than the given
// one, in the order added, with last set on the final result, or one result
// with face_valid low when none qualifies or the edge is missing. Equal
// vertices give one result with the degenerate status. After reset the block
// runs a clearing pass over all 1024 slots and holds in_ready low during it.
// A request is then taken in S_IDLE and the block stays busy until its last
// result is loaded into the output register: the slot index is formed in
// S_HASH1, S_HASH2 and S_HASH3 on the one shared multiplier, each slot probed
// passes S_READ and S_CHECK through the registered read of the slot memory,
// for a query each stored face read from the face memory passes S_FREAD and
// S_FCHK and a final S_FREAD ends the walk, and each result is loaded in
// S_EMIT, which waits while the output register holds an untaken result.
`timescale 1ns / 1ps

module edge_face_hash_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [efht_pkg::VERTEX_W-1:0] vertex_a,
  input  logic [efht_pkg::VERTEX_W-1:0] vertex_b,
  input  logic [efht_pkg::FACE_W-1:0]   face_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [efht_pkg::FACE_W-1:0]   other_face,
  output logic                          face_valid,
  output logic [efht_pkg::STATUS_W-1:0] status,
  output logic                          last
);

  import efht_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_HASH3,
    S_READ,
    S_CHECK,
    S_FREAD,
    S_FCHK,
    S_EMIT
  } state_t;

  state_t                state;
  logic [SLOT_W-1:0]     clr_addr;
  logic [EDGE_W-1:0]     edge_count;

  // Request registers.
  logic                  func_r;
  logic [FACE_W-1:0]     face_r;
  logic [VERTEX_W-1:0]   lo;
  logic [VERTEX_W-1:0]   hi;

  // Hash and probe registers.
  logic [HASH_W-1:0]     acc;
  logic [SLOT_W-1:0]     pos;

  // Face walk and result registers.
  logic [CNT_W-1:0]      fidx;
  logic [CNT_W-1:0]      face_cnt;
  logic [FACE_W-1:0]     face_buf [RESULT_LIMIT];
  logic [RES_CNT_W-1:0]  em_cnt;
  logic [RES_CNT_W-1:0]  em_idx;
  logic [STATUS_W-1:0]   em_status;

  // Memory ports.
  logic                  slot_we;
  logic [SLOT_W-1:0]     slot_waddr;
  slot_t                 slot_wr;
  logic [$bits(slot_t)-1:0] slot_rdata;
  slot_t                 slot_rd;
  logic                  face_we;
  logic [FADDR_W-1:0]    face_waddr;
  logic [FADDR_W-1:0]    face_raddr;
  logic [FACE_W-1:0]     face_rdata;

  // Combinational helpers.
  logic                  accept;
  logic                  a_less;
  logic [VERTEX_W-1:0]   mul_a;
  logic [MULT_W-1:0]     mul_b;
  logic [VERTEX_W+MULT_W-1:0] mul_full;
  logic [HASH_W-1:0]     acc_sum;
  logic [SLOT_W-1:0]     hash_slot;
  logic                  hit;
  logic                  table_full;
  logic [CNT_W-1:0]      cnt_clamped;
  logic                  out_free;
  logic                  emit_last;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign a_less   = (vertex_a < vertex_b);
  assign out_free = !out_valid || out_ready;

  // Shared multiply-accumulate unit: low vertex first, then high vertex.
  always_comb begin
    mul_a    = (state == S_HASH2) ? hi : lo;
    mul_b    = (state == S_HASH2) ? MULT_HIGH : MULT_LOW;
    mul_full = mul_a * mul_b;
    acc_sum  = ((state == S_HASH2) ? acc : '0) + mul_full[HASH_W-1:0];
  end

  // Signed remainder by the table size, then absolute value. Negation modulo
  // a power of two depends only on the low bits.
  assign hash_slot = acc[HASH_W-1] ? SLOT_W'(~acc[SLOT_W-1:0] + 1'b1)
                                   : acc[SLOT_W-1:0];

  // Probe compare on the slot that was read.
  assign slot_rd     = slot_t'(slot_rdata);
  assign hit         = slot_rd.used && (slot_rd.low == lo) && (slot_rd.high == hi);
  assign table_full  = (edge_count >= EDGE_W'(FULL_LIMIT));
  assign cnt_clamped = (slot_rd.count > CNT_W'(MAX_FACES)) ? CNT_W'(MAX_FACES)
                                                           : slot_rd.count;
  assign face_raddr  = FADDR_W'(int'(pos) * MAX_FACES + int'(fidx));
  assign emit_last   = (em_cnt == '0) || (RES_CNT_W'(em_idx + 1'b1) == em_cnt);

  // Memory write decode: clearing pass, new edge, or face append.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = pos;
    slot_wr    = '0;
    face_we    = 1'b0;
    face_waddr = FADDR_W'(int'(pos) * MAX_FACES);
    if (state == S_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_addr;
    end else if (state == S_CHECK && func_r == FUNC_ADD) begin
      if (!slot_rd.used && !table_full) begin
        slot_we       = 1'b1;
        slot_wr.used  = 1'b1;
        slot_wr.count = CNT_W'(1);
        slot_wr.low   = lo;
        slot_wr.high  = hi;
        face_we       = 1'b1;
      end else if (hit && slot_rd.count < CNT_W'(MAX_FACES)) begin
        slot_we       = 1'b1;
        slot_wr.used  = 1'b1;
        slot_wr.count = CNT_W'(slot_rd.count + 1'b1);
        slot_wr.low   = lo;
        slot_wr.high  = hi;
        face_we       = 1'b1;
        face_waddr    = FADDR_W'(int'(pos) * MAX_FACES + int'(slot_rd.count));
      end
    end
  end

  efht_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wr),
    .raddr (pos),
    .rdata (slot_rdata)
  );

  efht_ram #(
    .WIDTH (FACE_W),
    .DEPTH (FACE_DEPTH)
  ) u_face_ram (
    .clk   (clk),
    .we    (face_we),
    .waddr (face_waddr),
    .wdata (face_r),
    .raddr (face_raddr),
    .rdata (face_rdata)
  );

  // Sequencer, request registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      edge_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The emit state loads the next result itself when this one leaves.
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= SLOT_W'(clr_addr + 1'b1);
          if (clr_addr == SLOT_W'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_r    <= func;
            face_r    <= face_id;
            lo        <= a_less ? vertex_a : vertex_b;
            hi        <= a_less ? vertex_b : vertex_a;
            em_cnt    <= '0;
            em_idx    <= '0;
            em_status <= (vertex_a == vertex_b) ? ST_DEGENERATE : ST_OK;
            if (vertex_a == vertex_b) begin
              state <= S_EMIT;
            end else begin
              state <= S_HASH1;
            end
          end
        end
        S_HASH1: begin
          acc   <= acc_sum;
          state <= S_HASH2;
        end
        S_HASH2: begin
          acc   <= acc_sum;
          state <= S_HASH3;
        end
        S_HASH3: begin
          pos   <= hash_slot;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          // The table stays under half load, so the probe always meets an
          // empty slot before it wraps around.
          if (!slot_rd.used) begin
            if (func_r == FUNC_QUERY) begin
              em_status <= ST_NOT_FOUND;
            end else if (table_full) begin
              em_status <= ST_TABLE_FULL;
            end else begin
              edge_count <= EDGE_W'(edge_count + 1'b1);
            end
            state <= S_EMIT;
          end else if (hit) begin
            if (func_r == FUNC_ADD) begin
              if (slot_rd.count >= CNT_W'(MAX_FACES)) begin
                em_status <= ST_LIST_FULL;
              end
              state <= S_EMIT;
            end else begin
              fidx     <= '0;
              face_cnt <= cnt_clamped;
              state    <= S_FREAD;
            end
          end else begin
            pos   <= SLOT_W'(pos + 1'b1);
            state <= S_READ;
          end
        end
        S_FREAD: begin
          if (fidx >= face_cnt) begin
            state <= S_EMIT;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          // Keep every stored face other than the excluded one.
          if (face_rdata != face_r && em_cnt < RES_CNT_W'(RESULT_LIMIT)) begin
            face_buf[em_cnt[RES_IDX_W-1:0]] <= face_rdata;
            em_cnt <= RES_CNT_W'(em_cnt + 1'b1);
          end
          fidx  <= CNT_W'(fidx + 1'b1);
          state <= S_FREAD;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            last      <= emit_last;
            if (em_cnt == '0) begin
              other_face <= '0;
              face_valid <= 1'b0;
              status     <= em_status;
            end else begin
              other_face <= face_buf[em_idx[RES_IDX_W-1:0]];
              face_valid <= 1'b1;
              status     <= ST_OK;
            end
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              em_idx <= RES_CNT_W'(em_idx + 1'b1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/efht_checker.sv
`timescale 1ns / 1ps

module efht_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [efht_pkg::FACE_W-1:0]   other_face,
  input logic                          face_valid,
  input logic [efht_pkg::STATUS_W-1:0] status,
  input logic                          last
);

  import efht_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(other_face) &&
      $stable(face_valid) && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  // A face id is only ever returned with an ok status.
  a_face_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && face_valid |-> status == ST_OK)
    else $error("face returned with error status");

  // A result without a face carries a zero face id.
  a_face_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !face_valid |-> other_face == '0)
    else $error("nonzero face id without face_valid");

  // An error ends the request's results.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("error result not marked last");

  // The clearing pass after reset takes no requests.
  a_clear_busy: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken during clearing pass");

endmodule

bind edge_face_hash_table efht_checker u_efht_checker (.*);
